/* rtl/manchester_edge_timing_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Manchester edge timing decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_EDGE_TIMING_DECODER_MACROS_SVH
`define MANCHESTER_EDGE_TIMING_DECODER_MACROS_SVH

// same-cycle implication
`define MED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/med_pkg.sv */
// ----------------------------------------------------------------------------
// Manchester edge timing decoder package
// Widths, register indexes, phase codes and the item and result structs.
// ----------------------------------------------------------------------------
package med_pkg;

  localparam int TIME_WIDTH = 16;
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_HALF_MIN = 3'd0;
  localparam cfg_idx_t CFG_HALF_MAX = 3'd1;
  localparam cfg_idx_t CFG_FULL_MIN = 3'd2;
  localparam cfg_idx_t CFG_FULL_MAX = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT  = 3'd4;
  localparam cfg_idx_t CFG_WORD_LEN = 3'd5;

  localparam time_t RST_HALF_MIN = 16'd450;
  localparam time_t RST_HALF_MAX = 16'd550;
  localparam time_t RST_FULL_MIN = 16'd950;
  localparam time_t RST_FULL_MAX = 16'd1050;
  localparam time_t RST_TIMEOUT  = 16'd1200;
  localparam cnt_t  RST_WORD_LEN = 6'd32;

  localparam cnt_t WORD_LEN_MAX = CNT_W'(WORD_WIDTH);
  localparam cnt_t WORD_LEN_MIN = 6'd1;

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_START    = 2'd1,
    PH_MID_RISE = 2'd2,
    PH_MID_FALL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CL_BAD  = 2'd0,
    CL_HALF = 2'd1,
    CL_FULL = 2'd2
  } width_class_t;

  typedef struct packed {
    time_t half_min;
    time_t half_max;
    time_t full_min;
    time_t full_max;
    time_t timeout;
    cnt_t  word_bits;
  } cfg_t;

  typedef struct packed {
    logic  req_type;
    time_t now_time;
    logic  edge_rising;
    time_t edge_time;
  } item_t;

  typedef struct packed {
    logic   word_done;
    word_t  received_word;
    logic   sync_lost;
    logic   timed_out;
    phase_t rx_phase;
  } result_t;

endpackage

/* rtl/med_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for the width windows, timeout and word length.
// ----------------------------------------------------------------------------
module med_cfg
  import med_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_min  <= RST_HALF_MIN;
      cfg_r.half_max  <= RST_HALF_MAX;
      cfg_r.full_min  <= RST_FULL_MIN;
      cfg_r.full_max  <= RST_FULL_MAX;
      cfg_r.timeout   <= RST_TIMEOUT;
      cfg_r.word_bits <= RST_WORD_LEN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_MIN: cfg_r.half_min  <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_HALF_MAX: cfg_r.half_max  <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_FULL_MIN: cfg_r.full_min  <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_FULL_MAX: cfg_r.full_max  <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_TIMEOUT:  cfg_r.timeout   <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_WORD_LEN: cfg_r.word_bits <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/med_classify.sv */
// ----------------------------------------------------------------------------
// Pulse width classifier
// Sorts a pulse width into half bit, full bit or invalid; half bit wins.
// ----------------------------------------------------------------------------
module med_classify
  import med_pkg::*;
(
  input  time_t        width,
  input  cfg_t         cfg,
  output width_class_t cls
);

  logic in_half;
  logic in_full;

  assign in_half = (width >= cfg.half_min) && (width <= cfg.half_max);
  assign in_full = (width >= cfg.full_min) && (width <= cfg.full_max);

  always_comb begin
    if (in_half) begin
      cls = CL_HALF;
    end else if (in_full) begin
      cls = CL_FULL;
    end else begin
      cls = CL_BAD;
    end
  end

endmodule

/* rtl/med_core.sv */
// ----------------------------------------------------------------------------
// Decoder core
// Receiver state and the single-pass next-state logic for one item.
// ----------------------------------------------------------------------------
module med_core
  import med_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t phase_r, phase_nxt;
  time_t  rise_r, rise_nxt;
  time_t  mid_r, mid_nxt;
  time_t  last_r, last_nxt;
  word_t  shift_r, shift_nxt;
  cnt_t   left_r, left_nxt;
  word_t  held_r, held_nxt;

  time_t        gap;
  logic         tout;
  phase_t       ph;
  time_t        width;
  width_class_t cls;
  cnt_t         word_len;
  cnt_t         left_dec;
  logic         want_rise;
  logic         done;
  logic         lost;

  assign gap   = item.now_time - last_r;
  assign tout  = gap > cfg.timeout;
  assign ph    = tout ? PH_HUNT : phase_r;
  assign width = item.edge_time - ((ph == PH_START) ? rise_r : mid_r);

  med_classify u_classify (
    .width (width),
    .cfg   (cfg),
    .cls   (cls)
  );

  always_comb begin
    if (cfg.word_bits == '0) begin
      word_len = WORD_LEN_MIN;
    end else if (cfg.word_bits > WORD_LEN_MAX) begin
      word_len = WORD_LEN_MAX;
    end else begin
      word_len = cfg.word_bits;
    end
  end

  assign left_dec  = left_r - 1'b1;
  assign want_rise = (ph == PH_MID_RISE);

  always_comb begin
    phase_nxt = ph;
    rise_nxt  = rise_r;
    mid_nxt   = mid_r;
    last_nxt  = last_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    held_nxt  = held_r;
    done      = 1'b0;
    lost      = 1'b0;
    if (item.req_type) begin
      last_nxt = item.edge_time;
      case (ph)
        PH_HUNT: begin
          if (item.edge_rising) begin
            rise_nxt  = item.edge_time;
            phase_nxt = PH_START;
          end
        end
        PH_START: begin
          if (!item.edge_rising && cls == CL_FULL) begin
            shift_nxt = '0;
            mid_nxt   = item.edge_time;
            left_nxt  = word_len;
            phase_nxt = PH_MID_RISE;
          end else begin
            phase_nxt = PH_HUNT;
            lost      = 1'b1;
          end
        end
        default: begin
          if (item.edge_rising != want_rise) begin
            phase_nxt = PH_HUNT;
            lost      = 1'b1;
          end else if (cls == CL_HALF) begin
            phase_nxt = want_rise ? PH_MID_FALL : PH_MID_RISE;
          end else if (cls == CL_FULL) begin
            shift_nxt = {shift_r[WORD_WIDTH-2:0], item.edge_rising};
            left_nxt  = left_dec;
            if (left_dec == '0) begin
              held_nxt  = {shift_r[WORD_WIDTH-2:0], item.edge_rising};
              done      = 1'b1;
              phase_nxt = PH_HUNT;
            end else begin
              mid_nxt   = item.edge_time;
              phase_nxt = want_rise ? PH_MID_FALL : PH_MID_RISE;
            end
          end else begin
            phase_nxt = PH_HUNT;
            lost      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rise_r  <= '0;
      mid_r   <= '0;
      last_r  <= '0;
      shift_r <= '0;
      left_r  <= '0;
      held_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      mid_r   <= mid_nxt;
      last_r  <= last_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      held_r  <= held_nxt;
    end
  end

  assign res.word_done     = done;
  assign res.received_word = held_nxt;
  assign res.sync_lost     = lost;
  assign res.timed_out     = tout;
  assign res.rx_phase      = phase_nxt;

endmodule

/* rtl/manchester_edge_timing_decoder.sv */
// Pipeline: an accepted item is held in the input register, then its result in the result register.
// Throughput: 1 item per cycle while out_stall does not back up the pipe; the receiver state loop closes in the core.
// A result waiting on out_stall still lets one more item into the input register.
// Reset (rst_n low, synchronous): both stages empty, receiver hunting, state
// cleared, configuration back to 450/550/950/1050/1200/32.
// ----------------------------------------------------------------------------
// Manchester edge timing decoder
// Decodes Manchester bits from timestamped edges, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "manchester_edge_timing_decoder_macros.svh"

module manchester_edge_timing_decoder
  import med_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [TIME_WIDTH-1:0] in_now_time,
  input  logic                  in_edge_rising,
  input  logic [TIME_WIDTH-1:0] in_edge_time,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_word_done,
  output logic [WORD_WIDTH-1:0] out_received_word,
  output logic                  out_sync_lost,
  output logic                  out_timed_out,
  output logic [1:0]            out_rx_phase,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  logic    s1_v_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    adv;
  logic    in_take;

  med_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.req_type    <= in_req_type;
      s1_item_r.now_time    <= in_now_time;
      s1_item_r.edge_rising <= in_edge_rising;
      s1_item_r.edge_time   <= in_edge_time;
    end
  end

  med_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word_done     = out_res_r.word_done;
  assign out_received_word = out_res_r.received_word;
  assign out_sync_lost     = out_res_r.sync_lost;
  assign out_timed_out     = out_res_r.timed_out;
  assign out_rx_phase      = out_res_r.rx_phase;

  `MED_ASSERT_IMP(a_done_hunts, out_valid_r && out_res_r.word_done, out_res_r.rx_phase == PH_HUNT, "word done without return to hunt")
  `MED_ASSERT_IMP(a_lost_hunts, out_valid_r && out_res_r.sync_lost, out_res_r.rx_phase == PH_HUNT, "sync lost without return to hunt")
  `MED_ASSERT_IMP(a_done_xor_lost, out_valid_r, !(out_res_r.word_done && out_res_r.sync_lost), "word done and sync lost together")
  `MED_ASSERT_IMP(a_stall_cause, in_stall, s1_v_r && out_valid_r && out_stall, "input stalled with room downstream")
  `MED_ASSERT_NXT(a_adv_fills, adv, out_valid_r, "advanced item did not reach result register")

endmodule

/* dv/manchester_edge_timing_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Manchester edge timing decoder testbench
// Feeds time polls and timestamped edges through the valid/stall channels:
// directed corner items, then well-formed frames with random bits mixed with
// broken frames and noise, under several register settings. A scoreboard
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
import med_pkg::*;

class manchester_rx_model;
  cfg_t         regs;
  phase_t       rx_state;
  time_t        rise_at, mid_at, last_edge_at;
  word_t        shift_word, held_word;
  cnt_t         bits_left;
  result_t      pending_results[$];
  int           failures;

  function new();
    regs.half_min  = RST_HALF_MIN;
    regs.half_max  = RST_HALF_MAX;
    regs.full_min  = RST_FULL_MIN;
    regs.full_max  = RST_FULL_MAX;
    regs.timeout   = RST_TIMEOUT;
    regs.word_bits = RST_WORD_LEN;
    rx_state     = PH_HUNT;
    rise_at      = '0;
    mid_at       = '0;
    last_edge_at = '0;
    shift_word   = '0;
    held_word    = '0;
    bits_left    = '0;
    failures     = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HALF_MIN: regs.half_min = data;
      CFG_HALF_MAX: regs.half_max = data;
      CFG_FULL_MIN: regs.full_min = data;
      CFG_FULL_MAX: regs.full_max = data;
      CFG_TIMEOUT:  regs.timeout = data;
      CFG_WORD_LEN: regs.word_bits = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // half-bit window wins where the two windows overlap
  function width_class_t classify(time_t width);
    if (width >= regs.half_min && width <= regs.half_max) return CL_HALF;
    if (width >= regs.full_min && width <= regs.full_max) return CL_FULL;
    return CL_BAD;
  endfunction

  function void note_item(item_t it);
    result_t      r;
    time_t        gap;
    width_class_t cls;
    logic         want_rise;
    r = '0;
    gap = it.now_time - last_edge_at;
    if (gap > regs.timeout) begin
      rx_state = PH_HUNT;
      r.timed_out = 1'b1;
    end
    if (it.req_type) begin
      last_edge_at = it.edge_time;
      case (rx_state)
        PH_HUNT: begin
          if (it.edge_rising) begin
            rise_at = it.edge_time;
            rx_state = PH_START;
          end
        end
        PH_START: begin
          if (!it.edge_rising && classify(it.edge_time - rise_at) == CL_FULL) begin
            shift_word = '0;
            mid_at = it.edge_time;
            bits_left = regs.word_bits;
            if (bits_left == '0) bits_left = WORD_LEN_MIN;
            if (bits_left > WORD_LEN_MAX) bits_left = WORD_LEN_MAX;
            rx_state = PH_MID_RISE;
          end else begin
            rx_state = PH_HUNT;
            r.sync_lost = 1'b1;
          end
        end
        default: begin
          want_rise = (rx_state == PH_MID_RISE);
          cls = classify(it.edge_time - mid_at);
          if (it.edge_rising != want_rise || cls == CL_BAD) begin
            rx_state = PH_HUNT;
            r.sync_lost = 1'b1;
          end else if (cls == CL_HALF) begin
            rx_state = want_rise ? PH_MID_FALL : PH_MID_RISE;
          end else begin
            shift_word = {shift_word[WORD_WIDTH-2:0], it.edge_rising};
            bits_left = bits_left - 1'b1;
            if (bits_left == '0) begin
              held_word = shift_word;
              r.word_done = 1'b1;
              rx_state = PH_HUNT;
            end else begin
              mid_at = it.edge_time;
              rx_state = want_rise ? PH_MID_FALL : PH_MID_RISE;
            end
          end
        end
      endcase
    end
    r.received_word = held_word;
    r.rx_phase = rx_state;
    pending_results.push_back(r);
  endfunction

  function void fail(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function void compare(string field, logic [WORD_WIDTH-1:0] want, logic [WORD_WIDTH-1:0] got);
    if (want !== got)
      fail($sformatf("mismatch on %s: expected %0h, got %0h", field, want, got));
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      fail($sformatf("result with nothing expected: %h", got));
      return;
    end
    want = pending_results.pop_front();
    compare("word_done", want.word_done, got.word_done);
    compare("received_word", want.received_word, got.received_word);
    compare("sync_lost", want.sync_lost, got.sync_lost);
    compare("timed_out", want.timed_out, got.timed_out);
    compare("rx_phase", want.rx_phase, got.rx_phase);
  endfunction

  function int results_owed();
    return pending_results.size();
  endfunction
endclass

module manchester_edge_timing_decoder_tb
  import med_pkg::*;
;
  localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_stall, in_req_type, in_edge_rising;
  time_t                 in_now_time, in_edge_time;
  logic                  out_valid, out_stall, out_word_done, out_sync_lost, out_timed_out;
  word_t                 out_received_word;
  logic [1:0]            out_rx_phase;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  manchester_rx_model rx_model = new();

  bit    calm;
  bit    held_once;
  int    hold_left;
  int    n_results;
  int    sent;
  int    h_lo, h_hi, f_lo, f_hi, tmo, word_len, jit_max;
  bit    frames_ok;
  time_t last_edge;

  manchester_edge_timing_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_now_time       (in_now_time),
    .in_edge_rising    (in_edge_rising),
    .in_edge_time      (in_edge_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_done     (out_word_done),
    .out_received_word (out_received_word),
    .out_sync_lost     (out_sync_lost),
    .out_timed_out     (out_timed_out),
    .out_rx_phase      (out_rx_phase),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin : watchdog
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_sink
    result_t got;
    out_stall <= 1'b0;
    n_results = 0;
    held_once = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.word_done     = out_word_done;
        got.received_word = out_received_word;
        got.sync_lost     = out_sync_lost;
        got.timed_out     = out_timed_out;
        got.rx_phase      = phase_t'(out_rx_phase);
        rx_model.check_result(got);
        n_results++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_once && n_results >= 300) begin
        // long hold-off so the pipe fills and backs up the input
        held_once = 1'b1;
        hold_left = 60;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 25);
      end
    end
  end

  task automatic send_item(input logic req, input time_t now, input logic rising,
                           input time_t et);
    item_t it;
    it.req_type    = req;
    it.now_time    = now;
    it.edge_rising = rising;
    it.edge_time   = et;
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_now_time    <= now;
    in_edge_rising <= rising;
    in_edge_time   <= et;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rx_model.note_item(it);
    if (req) last_edge = et;
    sent++;
  endtask

  function automatic time_t pick_half();
    return time_t'($urandom_range(h_hi, h_lo));
  endfunction

  function automatic time_t pick_full();
    return time_t'($urandom_range(f_hi, f_lo));
  endfunction

  // edge item, sometimes preceded by a poll that stays inside the timeout
  task automatic send_edge(input logic rising, input time_t et);
    if ($urandom_range(3) == 0)
      send_item(1'b0, last_edge + time_t'($urandom_range(jit_max)), 1'($urandom),
                time_t'($urandom));
    send_item(1'b1, et + time_t'($urandom_range(jit_max)), rising, et);
  endtask

  task automatic spoil_frame(input time_t base);
    if ($urandom_range(2) == 2 && tmo < 65000)
      send_item(1'b0, last_edge + time_t'(tmo + 1 + $urandom_range(50)), 1'($urandom),
                time_t'($urandom));
    else
      send_edge(1'($urandom), base + time_t'($urandom_range(2 * f_hi + 20)));
  endtask

  task automatic send_frame(input bit broken);
    time_t mid, at;
    logic  want, b;
    int    spoil;
    spoil = broken ? int'($urandom_range(word_len)) : -1;
    at = last_edge + pick_full();
    send_edge(1'b1, at);
    if (spoil == 0) begin
      spoil_frame(at);
      return;
    end
    mid = at + pick_full();
    send_edge(1'b0, mid);
    want = 1'b1;
    for (int i = 1; i <= word_len; i++) begin
      b = 1'($urandom);
      if (spoil == i) begin
        spoil_frame(mid);
        return;
      end
      if (b != want) send_edge(want, mid + pick_half());
      at = mid + pick_full();
      send_edge(b, at);
      mid = at;
      want = !b;
    end
  endtask

  task automatic send_noise();
    time_t et;
    et = time_t'($urandom);
    send_item(1'($urandom), $urandom_range(1) ? et : time_t'($urandom), 1'($urandom), et);
  endtask

  task automatic run_phase(input int budget);
    int goal, pick;
    goal = sent + budget;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (!frames_ok || pick < 15) send_noise();
      else send_frame(pick < 32);
    end
  endtask

  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    for (guard = 0; rx_model.results_owed() != 0 && guard < 5000; guard++)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    rx_model.set_reg(idx, data);
  endtask

  function automatic void adopt_limits(int hmin, int hmax, int fmin, int fmax, int tmo_v,
                                       logic [CFG_DATA_W-1:0] wb_raw);
    h_lo = hmin;
    h_hi = hmax;
    f_lo = fmin;
    f_hi = fmax;
    tmo  = tmo_v;
    word_len = wb_raw[CNT_W-1:0];
    if (word_len == 0) word_len = 1;
    if (word_len > WORD_WIDTH) word_len = WORD_WIDTH;
    jit_max = (tmo > fmax) ? ((tmo - fmax > 50) ? 50 : tmo - fmax) : 0;
    frames_ok = (hmin <= hmax) && (fmin <= fmax) && (tmo > 0);
  endfunction

  task automatic apply_settings(input int hmin, input int hmax, input int fmin,
                                input int fmax, input int tmo_v,
                                input logic [CFG_DATA_W-1:0] wb_raw);
    settle();
    put_reg(CFG_HALF_MIN, CFG_DATA_W'(hmin));
    put_reg(CFG_HALF_MAX, CFG_DATA_W'(hmax));
    put_reg(CFG_FULL_MIN, CFG_DATA_W'(fmin));
    put_reg(CFG_FULL_MAX, CFG_DATA_W'(fmax));
    put_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo_v));
    put_reg(CFG_WORD_LEN, wb_raw);
    put_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    put_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    adopt_limits(hmin, hmax, fmin, fmax, tmo_v, wb_raw);
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= 1'b0;
    in_now_time    <= '0;
    in_edge_rising <= 1'b0;
    in_edge_time   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_HALF_MIN;
    cfg_wdata      <= '0;
    calm = 1'b0;
    sent = 0;
    last_edge = '0;
    adopt_limits(RST_HALF_MIN, RST_HALF_MAX, RST_FULL_MIN, RST_FULL_MAX, RST_TIMEOUT,
                 CFG_DATA_W'(RST_WORD_LEN));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // polls, timeout while hunting, falling edge ignored while hunting
    send_item(1'b0, 16'd0, 1'b1, 16'hFFFF);
    send_item(1'b0, 16'd1201, 1'b0, 16'h0000);
    send_item(1'b1, 16'd1300, 1'b0, 16'd1300);
    // start pulse of half width, of bad width, with wrong polarity
    send_item(1'b1, 16'd1400, 1'b1, 16'd1400);
    send_item(1'b1, 16'd1900, 1'b0, 16'd1900);
    send_item(1'b1, 16'd2000, 1'b1, 16'd2000);
    send_item(1'b1, 16'd2700, 1'b0, 16'd2700);
    send_item(1'b1, 16'd2800, 1'b1, 16'd2800);
    send_item(1'b1, 16'd3800, 1'b1, 16'd3800);
    // timeout and start on one item, then bits across the timer wrap
    send_item(1'b1, 16'd65000, 1'b1, 16'd65000);
    send_item(1'b1, 16'd464, 1'b0, 16'd464);
    send_item(1'b1, 16'd964, 1'b1, 16'd964);
    send_item(1'b1, 16'd1464, 1'b0, 16'd1464);
    send_item(1'b1, 16'd2464, 1'b1, 16'd2464);
    send_item(1'b1, 16'd3464, 1'b1, 16'd3464);
    // bad data width, then timeout in the middle of a word
    send_item(1'b1, 16'd4000, 1'b1, 16'd4000);
    send_item(1'b1, 16'd5000, 1'b0, 16'd5000);
    send_item(1'b1, 16'd6100, 1'b1, 16'd6100);
    send_item(1'b1, 16'd7000, 1'b1, 16'd7000);
    send_item(1'b1, 16'd8000, 1'b0, 16'd8000);
    send_item(1'b0, 16'd9201, 1'b1, 16'd8000);
    send_item(1'b0, 16'hFFFF, 1'b1, 16'h0000);
    send_item(1'b1, 16'h0000, 1'b1, 16'hFFFF);

    run_phase(110);
    apply_settings(10, 14, 20, 28, 40, 16'h0001);
    calm = 1'b1;
    run_phase(110);
    calm = 1'b0;
    apply_settings(0, 5000, 30000, 65535, 65535, 16'hFFC0);
    run_phase(100);
    apply_settings(100, 300, 200, 400, 500, 16'hAB08);
    run_phase(110);
    apply_settings(2000, 2100, 4000, 4200, 4300, 16'h003F);
    run_phase(110);
    apply_settings(65535, 65535, 65535, 0, 0, 16'h0021);
    run_phase(90);
    apply_settings(50, 70, 100, 140, 200, 16'hA5C5);
    run_phase(110);

    settle();
    if (rx_model.results_owed() != 0)
      rx_model.fail($sformatf("%0d results never arrived", rx_model.results_owed()));
    repeat (8) @(posedge clk);
    if (rx_model.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
